// File: hdl/acdr_pkg.sv
// Shared constants for the accel/decel reference ramp.
`default_nettype none
package acdr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int REF_W         = 16;
  localparam int TICKS_W       = 16;
  localparam int CFG_ADDR_W    = 1;
  localparam int TDATA_W       = 24;

  localparam logic signed [REF_W-1:0] REF_ONE     = 16'sd16384;
  localparam logic signed [REF_W-1:0] REF_NEG_ONE = -16'sd16384;

  localparam logic [TICKS_W-1:0] TICKS_RST = 16'd1000;

  localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_TICKS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DECEL_TICKS = 1'd1;

endpackage
`default_nettype wire

// File: hdl/acdr_div.sv
// Serial restoring divider: signed delta by unsigned tick count, one bit per cycle.
`default_nettype none
module acdr_div #(
  parameter int ACC_W = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire signed [ACC_W-1:0]             dividend,
  input  wire        [acdr_pkg::TICKS_W-1:0] divisor,
  output logic                               done,
  output logic signed [ACC_W-1:0]            quotient
);

  localparam int TW    = acdr_pkg::TICKS_W;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] q_r;
  logic [TW-1:0]    rem_r;
  logic [TW-1:0]    d_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [TW:0]      rem_sh;
  logic             ge;
  logic [TW:0]      rem_sub;
  logic [ACC_W-1:0] mag;

  assign mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign rem_sh  = {rem_r, q_r[ACC_W-1]};
  assign ge      = (rem_sh >= {1'b0, d_r});
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(ACC_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[ACC_W-1];
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[ACC_W-2:0], ge};
      rem_r <= ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
    end
  end

  // truncate toward zero: divide magnitudes, restore sign
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);
  assign done     = done_r;

endmodule
`default_nettype wire

// File: hdl/accel_decel_reference_ramp_core.sv
// Sequence: an input beat taken in idle passes through S_PREP to S_UPD, which raises
// out_tvalid, when the target is unchanged; a new target adds two serial divisions on the
// shared divider (S_DIVA, then S_DIVD; one quotient bit per cycle) before S_UPD.
// A new beat is taken only once the last one is through: in_tready is high only
// while idle, and a result held back by out_tready stalls the sequencer.
// Reset (rst_n low, synchronous): zero accumulator, steps, last target; lengths 1000.
`default_nettype none
module accel_decel_reference_ramp_core #(
  parameter int FRAC_BITS = acdr_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // [15:0] target_ref, [16] drive_on, [17] stop_cmd, [23:18] zero
  input  wire  [acdr_pkg::TDATA_W-1:0]          in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // [15:0] ramp_ref, [16] accelerating, [17] decelerating, [23:18] zero
  output logic [acdr_pkg::TDATA_W-1:0]          out_tdata,
  input  wire                                   cfg_we,
  input  wire  [acdr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [acdr_pkg::TICKS_W-1:0]          cfg_wdata
);

  localparam int RW    = acdr_pkg::REF_W;
  localparam int TW    = acdr_pkg::TICKS_W;
  localparam int ACC_W = RW + FRAC_BITS;
  localparam int DW    = ACC_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIVA = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  localparam logic signed [DW-1:0] LIM_P = $signed({{(DW-ACC_W+1){1'b0}}, 1'b1,
                                                    {(ACC_W-2){1'b0}}});
  localparam logic signed [DW-1:0] LIM_N = -LIM_P;

  logic [2:0]              state_r;
  logic [TW-1:0]           accel_ticks_r, decel_ticks_r;
  logic signed [RW-1:0]    tgt_r, last_target_r;
  logic signed [ACC_W-1:0] accum_r, accel_step_r, decel_step_r, dd_r;
  logic                    out_tvalid_r;
  logic [RW-1:0]           out_ref_r;
  logic                    out_acc_r, out_dec_r;

  // input decode
  logic signed [RW-1:0] in_tgt, tgt_sat, tgt_eff;
  logic                 in_on, in_stop;

  assign in_tgt  = $signed(in_tdata[RW-1:0]);
  assign in_on   = in_tdata[RW];
  assign in_stop = in_tdata[RW+1];

  always_comb begin
    if (in_tgt > acdr_pkg::REF_ONE) begin
      tgt_sat = acdr_pkg::REF_ONE;
    end else if (in_tgt < acdr_pkg::REF_NEG_ONE) begin
      tgt_sat = acdr_pkg::REF_NEG_ONE;
    end else begin
      tgt_sat = in_tgt;
    end
    tgt_eff = (!in_on || in_stop) ? '0 : tgt_sat;
  end

  // sign and magnitude relations of target and accumulator
  logic signed [ACC_W-1:0] s_val;
  logic [ACC_W-1:0]        as_v, ao_v;
  logic                    opposite, s_gt, s_lt;

  assign s_val    = $signed({tgt_r, {FRAC_BITS{1'b0}}});
  assign as_v     = s_val[ACC_W-1] ? ACC_W'(-s_val) : ACC_W'(s_val);
  assign ao_v     = accum_r[ACC_W-1] ? ACC_W'(-accum_r) : ACC_W'(accum_r);
  assign opposite = (s_val < 0 && accum_r > 0) || (s_val > 0 && accum_r < 0);
  assign s_gt     = as_v > ao_v;
  assign s_lt     = as_v < ao_v;

  // step deltas
  logic signed [ACC_W-1:0] ad_v, dd_v;

  always_comb begin
    if (opposite) begin
      ad_v = s_val;
      dd_v = accum_r;
    end else if (s_gt) begin
      ad_v = s_val - accum_r;
      dd_v = '0;
    end else if (s_lt) begin
      ad_v = '0;
      dd_v = accum_r - s_val;
    end else begin
      ad_v = '0;
      dd_v = '0;
    end
  end

  // shared divider
  logic                    div_start, div_done;
  logic signed [ACC_W-1:0] div_dividend, div_q;
  logic [TW-1:0]           div_divisor, accel_div, decel_div;

  assign accel_div = (accel_ticks_r == '0) ? TW'(1) : accel_ticks_r;
  assign decel_div = (decel_ticks_r == '0) ? TW'(1) : decel_ticks_r;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = ad_v;
    div_divisor  = accel_div;
    if (state_r == S_PREP && tgt_r != last_target_r) begin
      div_start = 1'b1;
    end else if (state_r == S_DIVA && div_done) begin
      div_start    = 1'b1;
      div_dividend = dd_r;
      div_divisor  = decel_div;
    end
  end

  acdr_div #(
    .ACC_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // accumulator update
  logic signed [DW-1:0] s_w, o_w, diff, acc_w, dec_w, o_nxt, o_clamp;
  logic [DW-1:0]        dist_mag, acc_mag, dec_mag;
  logic                 snap, upd_acc, upd_dec;

  assign s_w      = DW'(s_val);
  assign o_w      = DW'(accum_r);
  assign acc_w    = DW'(accel_step_r);
  assign dec_w    = DW'(decel_step_r);
  assign diff     = s_w - o_w;
  assign dist_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign acc_mag  = acc_w[DW-1] ? DW'(-acc_w) : DW'(acc_w);
  assign dec_mag  = dec_w[DW-1] ? DW'(-dec_w) : DW'(dec_w);
  assign snap     = (dist_mag < dec_mag) || (dist_mag < acc_mag);

  always_comb begin
    o_nxt   = s_w;
    upd_acc = 1'b0;
    upd_dec = 1'b0;
    if (snap) begin
      o_nxt = s_w;
    end else if (opposite || s_lt) begin
      o_nxt   = o_w - dec_w;
      upd_dec = 1'b1;
    end else if (s_gt) begin
      o_nxt   = o_w + acc_w;
      upd_acc = 1'b1;
    end
    if (o_nxt > LIM_P) begin
      o_clamp = LIM_P;
    end else if (o_nxt < LIM_N) begin
      o_clamp = LIM_N;
    end else begin
      o_clamp = o_nxt;
    end
  end

  logic upd_go;
  assign upd_go = (state_r == S_UPD) && (!out_tvalid_r || out_tready);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_ticks_r <= acdr_pkg::TICKS_RST;
      decel_ticks_r <= acdr_pkg::TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        acdr_pkg::REG_ACCEL_TICKS: accel_ticks_r <= cfg_wdata;
        acdr_pkg::REG_DECEL_TICKS: decel_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      last_target_r <= '0;
      accel_step_r  <= '0;
      decel_step_r  <= '0;
      accum_r       <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      // drop the beat once taken, unless a new one replaces it
      if (out_tvalid_r && out_tready && !upd_go) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          // new target: recompute both steps
          state_r <= (tgt_r != last_target_r) ? S_DIVA : S_UPD;
        end
        S_DIVA: begin
          if (div_done) begin
            accel_step_r <= div_q;
            state_r      <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            decel_step_r <= div_q;
            state_r      <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            accum_r       <= o_clamp[ACC_W-1:0];
            last_target_r <= tgt_r;
            out_tvalid_r  <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      tgt_r <= tgt_eff;
    end
    if (state_r == S_PREP) begin
      dd_r <= dd_v;
    end
    if (upd_go) begin
      out_ref_r <= o_clamp[ACC_W-1:FRAC_BITS];
      out_acc_r <= upd_acc;
      out_dec_r <= upd_dec;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(acdr_pkg::TDATA_W-RW-2){1'b0}}, out_dec_r, out_acc_r, out_ref_r};

endmodule
`default_nettype wire
